// File: sv/text_console_writer_macros.svh
// Assertion macros shared by the text console writer RTL.
// Included by the controller and datapath; define NO_ASSERTIONS to drop the checks.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset
`define TCW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define TCW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCW_ASSERT(name, clk, rst_n, prop, msg)
`define TCW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by the interfaces and all modules.
package tcw_pkg;

    // Field widths of the channels
    localparam int MODE_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int CELL_W      = ATTR_W + CHAR_W;

    // Default screen geometry
    localparam int COLS_DEFAULT = 80;
    localparam int ROWS_DEFAULT = 25;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'd10;
    localparam logic [ATTR_W-1:0] CLEAR_ATTR_RESET = 8'd15;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PRINT = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Controller to datapath
    typedef struct packed {
        logic accept_open;  // input channel ready
        logic fill_run;     // write fill cell at sweep position and advance
        logic fill_zero;    // fill with zero instead of the blank cell
        logic copy_run;     // read sweep position for scroll copy and advance
        logic out_load;     // load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic  req_valid;
        mode_t mode;
        logic  scroll_needed;
        logic  sweep_last;
        logic  out_free;
    } dp_sts_t;

endpackage

// File: sv/tcw_if.sv
// Channel interfaces of the text console writer: request, response, configuration.
// Depends on tcw_pkg for field widths.
interface tcw_req_if
    import tcw_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [CHAR_W-1:0]      char_code;
    logic [ATTR_W-1:0]      attribute;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;

    modport source (output valid, mode, char_code, attribute, row, col, input ready);
    modport sink   (input valid, mode, char_code, attribute, row, col, output ready);
endinterface

interface tcw_rsp_if
    import tcw_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_col;
    logic [CELL_W-1:0]      cell_value;
    logic                   scrolled;

    modport source (output valid, cursor_row, cursor_col, cell_value, scrolled, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_value, scrolled, output ready);
endinterface

interface tcw_cfg_if
    import tcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] clear_attribute;

    modport source (output valid, clear_attribute, input ready);
    modport sink   (input valid, clear_attribute, output ready);
endinterface

// File: sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg and the assertion macros; drives the datapath via dp_cmd_t.
`include "text_console_writer_macros.svh"

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_CLEAR  = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fill_run  = 1'b1;
                cmd.fill_zero = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.accept_open = 1'b1;
                if (sts.req_valid)
                begin
                    if (sts.mode == MODE_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (sts.mode == MODE_PRINT && sts.scroll_needed)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.fill_run = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCROLL:
            begin
                cmd.copy_run = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Checks
    `TCW_ASSERT(a_load_needs_slot, clk, rst_n, cmd.out_load |-> sts.out_free, "result load while output busy")
    `TCW_ASSERT_NEXT(a_clear_starts, clk, rst_n, cmd.accept_open && sts.req_valid && sts.mode == MODE_CLEAR, cmd.fill_run && !cmd.accept_open, "clear did not start a fill sweep")
    `TCW_ASSERT_NEXT(a_scroll_starts, clk, rst_n, cmd.accept_open && sts.req_valid && sts.mode == MODE_PRINT && sts.scroll_needed, cmd.copy_run, "scroll did not start a copy sweep")

endmodule

// File: sv/tcw_datapath.sv
// Datapath of the text console writer: screen memory, cursor, sweep counters, result register.
// Depends on tcw_pkg, the channel interfaces and the assertion macros.
`include "text_console_writer_macros.svh"

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEFAULT,
    parameter int ROWS = ROWS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp,
    tcw_cfg_if.sink   cfg,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts
);

    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = ROWS * (2 ** COL_W);

    // Screen memory, row-major with each row padded to a power of two
    logic [CELL_W-1:0] mem [MEM_DEPTH];
    logic [CELL_W-1:0] rdata_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [ATTR_W-1:0] clear_attr_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  sw_row_reg;
    logic [ROW_W-1:0]  sw_row_next;
    logic [COL_W-1:0]  sw_col_reg;
    logic [COL_W-1:0]  sw_col_next;
    logic              copy_pend_reg;
    logic [ROW_W-1:0]  pend_row_reg;
    logic [COL_W-1:0]  pend_col_reg;
    logic              pend_blank_reg;
    logic [CELL_W-1:0] res_cell_reg;
    logic              res_read_reg;
    logic              res_scroll_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              take;
    mode_t             in_mode;
    logic              is_nl;
    logic [CELL_W-1:0] new_cell;
    logic [CELL_W-1:0] blank_cell;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;
    logic [ROW_W-1:0]  row_sat;
    logic [COL_W-1:0]  col_sat;
    logic [COL_W:0]    col_inc;
    logic              wrap;
    logic [ROW_W-1:0]  row_adv;
    logic [COL_W-1:0]  col_adv;
    logic              scroll_cond;
    logic              sweep_last;
    logic              sweep_step;

    // Input decode
    assign req.ready  = cmd.accept_open;
    assign take       = cmd.accept_open & req.valid;
    assign in_mode    = mode_t'(req.mode);
    assign is_nl      = (req.char_code == NEWLINE_CODE);
    assign new_cell   = {req.attribute, req.char_code};
    assign blank_cell = {clear_attr_reg, CHAR_W'(0)};

    // Position saturation for write and read cell
    always_comb
    begin
        row_ext = 32'(req.row);
        col_ext = 32'(req.col);
        row_sat = (row_ext > 32'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(req.row);
        col_sat = (col_ext > 32'(COLS - 1)) ? COL_W'(COLS - 1) : COL_W'(req.col);
    end

    // Cursor advance for print
    always_comb
    begin
        col_inc     = {1'b0, cur_col_reg} + (COL_W + 1)'(1);
        wrap        = is_nl || (col_inc >= (COL_W + 1)'(COLS));
        row_adv     = wrap ? cur_row_reg + ROW_W'(1) : cur_row_reg;
        col_adv     = wrap ? '0 : col_inc[COL_W-1:0];
        scroll_cond = (row_adv >= ROW_W'(ROWS - 2));
    end

    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (take && in_mode == MODE_PRINT)
        begin
            if (scroll_cond)
            begin
                cur_row_next = ROW_W'(ROWS - 3);
                cur_col_next = '0;
            end
            else
            begin
                cur_row_next = row_adv;
                cur_col_next = col_adv;
            end
        end
    end

    // Sweep counters: clear and reset fill start at row 0, scroll copy at row 2
    assign sweep_last = (sw_row_reg == ROW_W'(ROWS - 1)) && (sw_col_reg == COL_W'(COLS - 1));
    assign sweep_step = cmd.fill_run | cmd.copy_run;

    always_comb
    begin
        sw_row_next = sw_row_reg;
        sw_col_next = sw_col_reg;
        if (take)
        begin
            sw_row_next = (in_mode == MODE_PRINT) ? ROW_W'(2) : '0;
            sw_col_next = '0;
        end
        else if (sweep_step)
        begin
            if (sw_col_reg == COL_W'(COLS - 1))
            begin
                sw_col_next = '0;
                sw_row_next = sweep_last ? '0 : sw_row_reg + ROW_W'(1);
            end
            else
            begin
                sw_col_next = sw_col_reg + COL_W'(1);
            end
        end
    end

    // Write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {sw_row_reg, sw_col_reg};
        wr_data = new_cell;
        if (cmd.fill_run)
        begin
            wr_en   = 1'b1;
            wr_data = cmd.fill_zero ? '0 : blank_cell;
        end
        else if (copy_pend_reg)
        begin
            // Copy writes the cell read in the previous cycle one row up; the last row read turns into the blank row
            wr_en   = 1'b1;
            wr_addr = {pend_row_reg - ROW_W'(1), pend_col_reg};
            wr_data = pend_blank_reg ? blank_cell : rdata_reg;
        end
        else if (take && in_mode == MODE_PRINT && !is_nl)
        begin
            wr_en   = 1'b1;
            wr_addr = {cur_row_reg, cur_col_reg};
        end
        else if (take && in_mode == MODE_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = {row_sat, col_sat};
        end
    end

    // Read port select
    assign rd_en   = cmd.copy_run | (take & (in_mode == MODE_READ));
    assign rd_addr = cmd.copy_run ? {sw_row_reg, sw_col_reg} : {row_sat, col_sat};

    // Memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Output handshake
    assign out_valid_next = cmd.out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    assign rsp.valid      = out_valid_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_attr_reg <= CLEAR_ATTR_RESET;
            cur_row_reg    <= ROW_W'(1);
            cur_col_reg    <= '0;
            sw_row_reg     <= '0;
            sw_col_reg     <= '0;
            copy_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                clear_attr_reg <= cfg.clear_attribute;
            end
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            sw_row_reg    <= sw_row_next;
            sw_col_reg    <= sw_col_next;
            copy_pend_reg <= cmd.copy_run;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_row_reg   <= sw_row_reg;
        pend_col_reg   <= sw_col_reg;
        pend_blank_reg <= (sw_row_reg == ROW_W'(ROWS - 1));
        if (take)
        begin
            res_cell_reg   <= ((in_mode == MODE_PRINT && !is_nl) || in_mode == MODE_WRITE)
                              ? new_cell : '0;
            res_read_reg   <= (in_mode == MODE_READ);
            res_scroll_reg <= (in_mode == MODE_PRINT) && scroll_cond;
        end
        if (cmd.out_load)
        begin
            rsp.cursor_row <= ROW_FIELD_W'(cur_row_reg);
            rsp.cursor_col <= COL_FIELD_W'(cur_col_reg);
            rsp.cell_value <= res_read_reg ? rdata_reg : res_cell_reg;
            rsp.scrolled   <= res_scroll_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        sts.req_valid     = req.valid;
        sts.mode          = in_mode;
        sts.scroll_needed = scroll_cond;
        sts.sweep_last    = sweep_last;
        sts.out_free      = !out_valid_reg || rsp.ready;
    end

    // Checks
    `TCW_ASSERT(a_no_pend_at_accept, clk, rst_n, req.ready |-> !copy_pend_reg, "scroll copy still pending at accept")
    `TCW_ASSERT(a_col_in_range, clk, rst_n, cur_col_reg < COL_W'(COLS - 1) || cur_col_reg == COL_W'(COLS - 1), "cursor column out of range")
    `TCW_ASSERT_NEXT(a_row_in_range, clk, rst_n, take, cur_row_reg < ROW_W'(ROWS - 2), "cursor row reached scroll row")

endmodule

// File: sv/text_console_writer.sv
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_if, tcw_ctrl and tcw_datapath.

// Text console writer. Keeps a ROWS x COLS screen of 16-bit cells (attribute in the upper
// byte, character in the lower) in a one-write, one-read-port memory, and runs one
// transaction per request: print at the cursor, write a cell, read a cell, or clear.
// Print, write cell and read cell write or read the memory at the edge that takes the
// request; the response register is loaded from the response state once the output is
// free, as the controller returns to idle, so the next request can be taken while that
// response is valid. A print that scrolls walks rows 2 to ROWS-1 through the memory, one
// cell per cycle; clear fills the whole screen, one cell per cycle. A stalled response
// channel holds the next request in its final cycle until the previous response is taken.
// After reset a clearing pass zeroes the screen before the first request is taken;
// configuration writes are taken at any time.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEFAULT,
    parameter int ROWS = ROWS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    tcw_cfg_if.sink   cfg,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer
    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Screen memory and cursor
    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// File: tb/text_console_writer_tb.sv
// Self-checking testbench for text_console_writer: directed and random requests with
// configuration phases, each response checked against a screen predictor kept here.
// Depends on tcw_pkg, the channel interfaces in tcw_if and the text_console_writer RTL.
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int ROWS_N        = ROWS_DEFAULT;
    localparam int COLS_N        = COLS_DEFAULT;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int PHASES        = 6;
    localparam int CYCLE_LIMIT   = 12_000_000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        mode_t                  mode;
        logic [CHAR_W-1:0]      char_code;
        logic [ATTR_W-1:0]      attribute;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
    } console_request_t;

    typedef struct {
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [CELL_W-1:0]      cell_value;
        logic                   scrolled;
    } console_response_t;

    // Screen copy, cursor and clear attribute; predicts and checks responses
    class screen_mirror;
        logic [CELL_W-1:0]      cells [ROWS_N][COLS_N];
        logic [ROW_FIELD_W-1:0] cur_row;
        logic [COL_FIELD_W-1:0] cur_col;
        logic [ATTR_W-1:0]      blank_attr;
        console_response_t      predicted_responses [$];
        int                     mismatch_count;
        int                     checked_count;

        function new();
            foreach (cells[r, c]) cells[r][c] = '0;
            cur_row        = ROW_FIELD_W'(1);
            cur_col        = '0;
            blank_attr     = CLEAR_ATTR_RESET;
            mismatch_count = 0;
            checked_count  = 0;
        endfunction

        function void set_blank_attr(logic [ATTR_W-1:0] value);
            blank_attr = value;
        endfunction

        // Apply one accepted request and queue the response it must produce
        function void apply_request(console_request_t rq);
            console_response_t      rs;
            logic [CELL_W-1:0]      blank;
            logic [ROW_FIELD_W-1:0] r;
            logic [COL_FIELD_W-1:0] c;
            blank = {blank_attr, {CHAR_W{1'b0}}};
            r = (int'(rq.row) > ROWS_N - 1) ? ROW_FIELD_W'(ROWS_N - 1) : rq.row;
            c = (int'(rq.col) > COLS_N - 1) ? COL_FIELD_W'(COLS_N - 1) : rq.col;
            rs.cell_value = '0;
            rs.scrolled   = 1'b0;
            case (rq.mode)
                MODE_PRINT:
                begin
                    if (rq.char_code != NEWLINE_CODE)
                    begin
                        rs.cell_value = {rq.attribute, rq.char_code};
                        cells[cur_row][cur_col] = rs.cell_value;
                        cur_col++;
                    end
                    if (cur_col >= COLS_N || rq.char_code == NEWLINE_CODE)
                    begin
                        cur_row++;
                        cur_col = '0;
                    end
                    // scroll rows 2..ROWS-2 up by one, row 0 and the last row stay
                    if (cur_row >= ROWS_N - 2)
                    begin
                        for (int sr = 2; sr < ROWS_N - 1; sr++)
                            for (int sc = 0; sc < COLS_N; sc++)
                                cells[sr-1][sc] = cells[sr][sc];
                        for (int sc = 0; sc < COLS_N; sc++)
                            cells[ROWS_N-2][sc] = blank;
                        cur_row     = ROW_FIELD_W'(ROWS_N - 3);
                        cur_col     = '0;
                        rs.scrolled = 1'b1;
                    end
                end
                MODE_WRITE:
                begin
                    rs.cell_value = {rq.attribute, rq.char_code};
                    cells[r][c]   = rs.cell_value;
                end
                MODE_READ:
                    rs.cell_value = cells[r][c];
                default:
                    foreach (cells[i, j]) cells[i][j] = blank;
            endcase
            rs.cursor_row = cur_row;
            rs.cursor_col = cur_col;
            predicted_responses.push_back(rs);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("ERROR response %0d: %s", checked_count, what);
        endtask

        // Compare one accepted response with the oldest prediction
        task compare_response(console_response_t got);
            console_response_t want;
            checked_count++;
            if (predicted_responses.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
                return;
            end
            want = predicted_responses.pop_front();
            if (got.cursor_row !== want.cursor_row)
                report_mismatch($sformatf("cursor_row %0d, want %0d",
                                          got.cursor_row, want.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report_mismatch($sformatf("cursor_col %0d, want %0d",
                                          got.cursor_col, want.cursor_col));
            if (got.cell_value !== want.cell_value)
                report_mismatch($sformatf("cell_value %h, want %h",
                                          got.cell_value, want.cell_value));
            if (got.scrolled !== want.scrolled)
                report_mismatch($sformatf("scrolled %b, want %b",
                                          got.scrolled, want.scrolled));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int          send_gap_pct;
    int          stall_pct;
    screen_mirror board;

    tcw_cfg_if cfg_bus ();
    tcw_req_if req_bus ();
    tcw_rsp_if rsp_bus ();

    text_console_writer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #4 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("text_console_writer: mismatch");
        $finish;
    end

    // Idle span: mostly short, now and then long
    function automatic int pick_span();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    endfunction

    // Random byte, and row and column over the whole field range
    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ROW_FIELD_W-1:0] any_row();
        return ROW_FIELD_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [COL_FIELD_W-1:0] any_col();
        return COL_FIELD_W'($urandom_range(0, 127));
    endfunction

    // Row and column on the screen, now and then past its edge
    function automatic logic [ROW_FIELD_W-1:0] rand_row();
        if ($urandom_range(0, 7) == 0)
            return any_row();
        return ROW_FIELD_W'($urandom_range(0, ROWS_N - 1));
    endfunction

    function automatic logic [COL_FIELD_W-1:0] rand_col();
        if ($urandom_range(0, 7) == 0)
            return any_col();
        return COL_FIELD_W'($urandom_range(0, COLS_N - 1));
    endfunction

    function automatic console_request_t make_request(mode_t m, logic [CHAR_W-1:0] ch,
                                                      logic [ATTR_W-1:0] attr,
                                                      logic [ROW_FIELD_W-1:0] r,
                                                      logic [COL_FIELD_W-1:0] c);
        console_request_t rq;
        rq.mode      = m;
        rq.char_code = ch;
        rq.attribute = attr;
        rq.row       = r;
        rq.col       = c;
        return rq;
    endfunction

    // Response side: random back-pressure, driven at the falling edge
    initial
    begin
        int stall_left;
        stall_left    = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left = pick_span() - 1;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Response check on each accepted transaction
    always @(posedge clk)
    begin : rsp_check
        console_response_t seen;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            seen.cursor_row = rsp_bus.cursor_row;
            seen.cursor_col = rsp_bus.cursor_col;
            seen.cell_value = rsp_bus.cell_value;
            seen.scrolled   = rsp_bus.scrolled;
            board.compare_response(seen);
        end
    end

    // Send one request; entered and left at a falling edge
    task automatic send_request(console_request_t rq);
        int gap;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_span() : 0;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.mode      <= rq.mode;
        req_bus.char_code <= rq.char_code;
        req_bus.attribute <= rq.attribute;
        req_bus.row       <= rq.row;
        req_bus.col       <= rq.col;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        board.apply_request(rq);
        @(negedge clk);
    endtask

    // Wait until every predicted response has come back, then let the block settle
    task automatic drain_responses();
        req_bus.valid <= 1'b0;
        while (board.predicted_responses.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_clear_attribute(logic [ATTR_W-1:0] value);
        cfg_bus.valid           <= 1'b1;
        cfg_bus.clear_attribute <= value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        board.set_blank_attr(value);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random traffic: text lines, newline runs, cell writes and reads, rare clears
    task automatic run_random_phase(int budget);
        int                left;
        int                kind;
        int                len;
        logic [ATTR_W-1:0] line_attr;
        left = budget;
        while (left > 0)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // a line of text, sometimes long enough to wrap
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(COLS_N - 2, COLS_N + 12)
                                                  : $urandom_range(1, 30);
                line_attr = rand_byte();
                for (int k = 0; k < len && left > 0; k++)
                begin
                    send_request(make_request(MODE_PRINT, rand_byte(),
                                              ($urandom_range(0, 3) == 0) ? rand_byte()
                                                                          : line_attr,
                                              any_row(), any_col()));
                    left--;
                end
                if (left > 0 && $urandom_range(0, 9) < 7)
                begin
                    send_request(make_request(MODE_PRINT, NEWLINE_CODE, rand_byte(),
                                              any_row(), any_col()));
                    left--;
                end
            end
            else if (kind < 62)
            begin
                len = $urandom_range(1, ROWS_N - 1);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    send_request(make_request(MODE_PRINT, NEWLINE_CODE, rand_byte(),
                                              any_row(), any_col()));
                    left--;
                end
            end
            else if (kind < 76)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    send_request(make_request(MODE_WRITE, rand_byte(), rand_byte(),
                                              rand_row(), rand_col()));
                    left--;
                end
            end
            else if (kind < 94)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    send_request(make_request(MODE_READ, rand_byte(), rand_byte(),
                                              rand_row(), rand_col()));
                    left--;
                end
            end
            else if (kind < 97)
            begin
                send_request(make_request(MODE_CLEAR, rand_byte(), rand_byte(),
                                          any_row(), any_col()));
                left--;
            end
            else
            begin
                send_request(make_request(mode_t'($urandom_range(0, 3)), rand_byte(),
                                          rand_byte(), any_row(), any_col()));
                left--;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        logic [ATTR_W-1:0] phase_attr;
        board                   = new();
        rst_n                   = 1'b0;
        req_bus.valid           = 1'b0;
        req_bus.mode            = MODE_PRINT;
        req_bus.char_code       = '0;
        req_bus.attribute       = '0;
        req_bus.row             = '0;
        req_bus.col             = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.clear_attribute = '0;
        send_gap_pct            = 25;
        stall_pct               = 25;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset clear attribute: extremes, saturation, newline, clear
        send_request(make_request(MODE_READ,  8'h00, 8'h00, 5'd0,  7'd0));
        send_request(make_request(MODE_WRITE, 8'h00, 8'h00, 5'd0,  7'd0));
        send_request(make_request(MODE_WRITE, 8'hFF, 8'hFF, 5'd24, 7'd79));
        send_request(make_request(MODE_WRITE, 8'h5A, 8'hA5, 5'd31, 7'd127));
        send_request(make_request(MODE_READ,  8'h00, 8'h00, 5'd31, 7'd127));
        send_request(make_request(MODE_READ,  8'hFF, 8'hFF, 5'd24, 7'd79));
        send_request(make_request(MODE_WRITE, 8'h01, 8'h02, 5'd0,  7'd127));
        send_request(make_request(MODE_READ,  8'h00, 8'h00, 5'd31, 7'd0));
        send_request(make_request(MODE_PRINT, 8'h41, 8'h1E, 5'd31, 7'd127));
        send_request(make_request(MODE_PRINT, 8'h00, 8'h00, 5'd0,  7'd0));
        send_request(make_request(MODE_PRINT, 8'hFF, 8'hFF, 5'd0,  7'd0));
        send_request(make_request(MODE_PRINT, NEWLINE_CODE, 8'hFF, 5'd0, 7'd0));
        send_request(make_request(MODE_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127));
        send_request(make_request(MODE_READ,  8'h00, 8'h00, 5'd2,  7'd1));
        drain_responses();

        // Directed, all-ones clear attribute
        write_clear_attribute(8'hFF);
        send_request(make_request(MODE_WRITE, 8'h33, 8'h44, 5'd1,  7'd0));
        send_request(make_request(MODE_CLEAR, 8'h00, 8'h00, 5'd0,  7'd0));
        send_request(make_request(MODE_READ,  8'h00, 8'h00, 5'd1,  7'd0));
        send_request(make_request(MODE_PRINT, NEWLINE_CODE, 8'h00, 5'd31, 7'd127));
        send_request(make_request(MODE_WRITE, NEWLINE_CODE, 8'h80, 5'd3, 7'd5));
        send_request(make_request(MODE_READ,  8'h00, 8'h00, 5'd3,  7'd5));
        send_request(make_request(MODE_READ,  8'h00, 8'h00, 5'd2,  7'd127));

        // Random phases, each under its own clear attribute and idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            drain_responses();
            case (p)
                0:       phase_attr = 8'h00;
                1:       phase_attr = 8'hA5;
                3:       phase_attr = 8'h5A;
                5:       phase_attr = CLEAR_ATTR_RESET;
                default: phase_attr = rand_byte();
            endcase
            write_clear_attribute(phase_attr);
            send_gap_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
            stall_pct    = (p % 3 == 1) ? 0 : $urandom_range(10, 60);
            run_random_phase(RANDOM_ITEMS / PHASES);
        end
        drain_responses();

        if (board.mismatch_count == 0)
            $display("text_console_writer: match");
        else
            $display("text_console_writer: mismatch");
        $finish;
    end

endmodule
